// ===== src/twspm_pkg.sv =====
// Shared types, codes and constants for the two-wire serial programming master.
// Used by twspm_engine and two_wire_serial_programming_master; no dependencies.
package twspm_pkg;

   localparam int WORD_W  = 16;
   localparam int MODE_W  = 3;
   localparam int BITS_W  = 5;
   localparam int DELAY_W = 16;
   localparam int PHASE_W = 2;
   localparam int CSR_IDX_W = 2;

   localparam int COMMAND_BITS_DEFAULT = 8;
   localparam int WORD_BITS_DEFAULT    = 16;

   localparam logic [MODE_W-1:0] OP_IDLE  = 3'd0;
   localparam logic [MODE_W-1:0] OP_CMD   = 3'd1;
   localparam logic [MODE_W-1:0] OP_WRITE = 3'd2;
   localparam logic [MODE_W-1:0] OP_READ  = 3'd3;
   localparam logic [MODE_W-1:0] OP_ENTER = 3'd4;
   localparam logic [MODE_W-1:0] OP_EXIT  = 3'd5;

   localparam logic [PHASE_W-1:0] PHASE_SETUP = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_HIGH  = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_LOW   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_BIT_DELAY   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTER_DELAY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXIT_DELAY  = 2'd2;

   localparam logic [DELAY_W-1:0] BIT_DELAY_RESET   = 16'd50;
   localparam logic [DELAY_W-1:0] ENTER_DELAY_RESET = 16'd10;
   localparam logic [DELAY_W-1:0] EXIT_DELAY_RESET  = 16'd100;

   typedef struct packed {
      logic [DELAY_W-1:0] bit_delay;
      logic [DELAY_W-1:0] enter_delay;
      logic [DELAY_W-1:0] exit_delay;
   } cfg_type;

   typedef struct packed {
      logic              clock_level;
      logic              data_level;
      logic              data_drive;
      logic              busy_res;
      logic [WORD_W-1:0] read_word;
      logic              read_valid;
      logic              request_dropped;
   } rsp_type;

endpackage

// ===== src/two_wire_serial_programming_master.sv =====
// Two-wire serial programming master: input register, pin sequencer, result register.
// Depends on twspm_pkg and twspm_engine.
// An accepted transaction waits in the input register; its step result is held in the
// result register. Throughput: one transaction per cycle unless rsp_stall holds a full
// result register, set by the single-step sequencer between the two registers. Reset
// clears both stages, loads delays 50, 10 and 100, leaves clock and data high, driven.
module two_wire_serial_programming_master #(
   parameter int COMMAND_BITS = twspm_pkg::COMMAND_BITS_DEFAULT,
   parameter int WORD_BITS    = twspm_pkg::WORD_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [twspm_pkg::MODE_W-1:0]    req_mode,
   input  logic [twspm_pkg::WORD_W-1:0]    req_value,
   input  logic                            req_data_pin_in,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_clock_level,
   output logic                            rsp_data_level,
   output logic                            rsp_data_drive,
   output logic                            rsp_busy_res,
   output logic [twspm_pkg::WORD_W-1:0]    rsp_read_word,
   output logic                            rsp_read_valid,
   output logic                            rsp_request_dropped,
   input  logic                            csr_write,
   input  logic [twspm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [twspm_pkg::DELAY_W-1:0]   csr_wdata
);
   import twspm_pkg::*;

   cfg_type           cfg_ff;
   logic              s1_valid_ff, s1_valid_in;
   logic [MODE_W-1:0] mode_ff;
   logic [WORD_W-1:0] value_ff;
   logic              pin_ff;
   logic              s2_valid_ff, s2_valid_in;
   rsp_type           rsp_ff;
   rsp_type           step_res;
   logic              s2_free, step, req_accept;

   assign s2_free     = !s2_valid_ff || !rsp_stall;
   assign step        = s1_valid_ff && s2_free;
   assign req_stall   = s1_valid_ff && !s2_free;
   assign req_accept  = req_valid && !req_stall;
   assign s1_valid_in = req_accept ? 1'b1 : (step ? 1'b0 : s1_valid_ff);
   assign s2_valid_in = s2_free ? step : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_delay   <= BIT_DELAY_RESET;
         cfg_ff.enter_delay <= ENTER_DELAY_RESET;
         cfg_ff.exit_delay  <= EXIT_DELAY_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_BIT_DELAY:   cfg_ff.bit_delay   <= csr_wdata;
            CSR_ENTER_DELAY: cfg_ff.enter_delay <= csr_wdata;
            CSR_EXIT_DELAY:  cfg_ff.exit_delay  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff  <= req_mode;
         value_ff <= req_value;
         pin_ff   <= req_data_pin_in;
      end
      if (step) begin
         rsp_ff <= step_res;
      end
   end

   twspm_engine #(
      .COMMAND_BITS (COMMAND_BITS),
      .WORD_BITS    (WORD_BITS)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (step),
      .mode    (mode_ff),
      .value   (value_ff),
      .pin     (pin_ff),
      .cfg     (cfg_ff),
      .res     (step_res)
   );

   assign rsp_valid           = s2_valid_ff;
   assign rsp_clock_level     = rsp_ff.clock_level;
   assign rsp_data_level      = rsp_ff.data_level;
   assign rsp_data_drive      = rsp_ff.data_drive;
   assign rsp_busy_res        = rsp_ff.busy_res;
   assign rsp_read_word       = rsp_ff.read_word;
   assign rsp_read_valid      = rsp_ff.read_valid;
   assign rsp_request_dropped = rsp_ff.request_dropped;

   stalled_item_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_free |=> s1_valid_ff && $stable(mode_ff) && $stable(value_ff))
      else $error("waiting transaction lost or changed");

   step_fills_output: assert property (@(posedge clock) disable iff (reset)
      step |=> s2_valid_ff)
      else $error("stepped transaction produced no result");

endmodule

// ===== src/twspm_engine.sv =====
// Pin sequencer of the two-wire serial programming master: one tick per step.
// Depends on twspm_pkg for codes, the configuration struct and the result struct.
module twspm_engine #(
   parameter int COMMAND_BITS = twspm_pkg::COMMAND_BITS_DEFAULT,
   parameter int WORD_BITS    = twspm_pkg::WORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_en,
   input  logic [twspm_pkg::MODE_W-1:0]  mode,
   input  logic [twspm_pkg::WORD_W-1:0]  value,
   input  logic                          pin,
   input  twspm_pkg::cfg_type            cfg,
   output twspm_pkg::rsp_type            res
);
   import twspm_pkg::*;

   localparam int CMD_SHIFT  = WORD_W - COMMAND_BITS;
   localparam int WORD_SHIFT = WORD_W - WORD_BITS;

   logic [MODE_W-1:0]  op_ff,    op_in;
   logic [WORD_W-1:0]  shift_ff, shift_in;
   logic [BITS_W-1:0]  bits_ff,  bits_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [DELAY_W-1:0] wait_ff,  wait_in;
   logic               clk_ff,   clk_in;
   logic               data_ff,  data_in;
   logic               drive_ff, drive_in;
   logic [WORD_W-1:0]  last_ff,  last_in;

   logic [DELAY_W-1:0] bit_d, enter_d, exit_d;
   logic [BITS_W-1:0]  bits_dec;
   logic [WORD_W-1:0]  shift_cmd, shift_word, shift_next;
   logic               request, active, valid, dropped;

   function automatic logic [DELAY_W-1:0] at_least_one(input logic [DELAY_W-1:0] d);
      at_least_one = (d == '0) ? DELAY_W'(1) : d;
   endfunction

   always_comb begin
      bit_d      = at_least_one(cfg.bit_delay);
      enter_d    = at_least_one(cfg.enter_delay);
      exit_d     = at_least_one(cfg.exit_delay);
      shift_cmd  = value << CMD_SHIFT;
      shift_word = value << WORD_SHIFT;
      shift_next = {shift_ff[WORD_W-2:0], 1'b0};
      bits_dec   = (bits_ff != '0) ? bits_ff - BITS_W'(1) : '0;
      request    = (mode >= OP_CMD) && (mode <= OP_EXIT);
      active     = (op_ff != OP_IDLE);

      op_in    = op_ff;
      shift_in = shift_ff;
      bits_in  = bits_ff;
      phase_in = phase_ff;
      wait_in  = wait_ff;
      clk_in   = clk_ff;
      data_in  = data_ff;
      drive_in = drive_ff;
      last_in  = last_ff;
      valid    = 1'b0;
      dropped  = 1'b0;

      if (active) begin
         dropped = request;
         if (wait_ff > DELAY_W'(1)) begin
            wait_in = wait_ff - DELAY_W'(1);
         end else begin
            wait_in = '0;
            unique case (op_ff) inside
               OP_CMD, OP_WRITE: begin
                  if (phase_ff == PHASE_SETUP) begin
                     clk_in = 1'b1; phase_in = PHASE_HIGH; wait_in = bit_d;
                  end else if (phase_ff == PHASE_HIGH) begin
                     clk_in = 1'b0; phase_in = PHASE_LOW; wait_in = bit_d;
                  end else begin
                     bits_in = bits_dec;
                     if (bits_dec != '0) begin
                        shift_in = shift_next;
                        data_in  = shift_next[WORD_W-1];
                        phase_in = PHASE_SETUP;
                        wait_in  = bit_d;
                     end else begin
                        op_in = OP_IDLE; phase_in = PHASE_SETUP;
                     end
                  end
               end
               OP_READ: begin
                  if (phase_ff == PHASE_HIGH) begin
                     shift_in = {shift_ff[WORD_W-2:0], pin};
                     clk_in   = 1'b0; phase_in = PHASE_LOW; wait_in = bit_d;
                  end else begin
                     bits_in = bits_dec;
                     if (bits_dec != '0) begin
                        clk_in = 1'b1; phase_in = PHASE_HIGH; wait_in = bit_d;
                     end else begin
                        drive_in = 1'b1;
                        last_in  = shift_ff;
                        op_in    = OP_IDLE;
                        phase_in = PHASE_SETUP;
                        valid    = 1'b1;
                     end
                  end
               end
               OP_ENTER: begin
                  if (phase_ff == PHASE_SETUP) begin
                     data_in = 1'b1; phase_in = PHASE_HIGH; wait_in = enter_d;
                  end else if (phase_ff == PHASE_HIGH) begin
                     data_in = 1'b0; phase_in = PHASE_LOW; wait_in = enter_d;
                  end else begin
                     data_in = 1'b1; op_in = OP_IDLE; phase_in = PHASE_SETUP;
                  end
               end
               default: begin
                  op_in = OP_IDLE; phase_in = PHASE_SETUP;
               end
            endcase
         end
      end else if (request) begin
         op_in = mode;
         unique case (mode) inside
            OP_CMD: begin
               shift_in = shift_cmd;
               bits_in  = BITS_W'(COMMAND_BITS);
               drive_in = 1'b1;
               data_in  = shift_cmd[WORD_W-1];
               phase_in = PHASE_SETUP;
               wait_in  = bit_d;
            end
            OP_WRITE: begin
               shift_in = shift_word;
               bits_in  = BITS_W'(WORD_BITS);
               drive_in = 1'b1;
               data_in  = shift_word[WORD_W-1];
               phase_in = PHASE_SETUP;
               wait_in  = bit_d;
            end
            OP_READ: begin
               shift_in = '0;
               bits_in  = BITS_W'(WORD_BITS);
               drive_in = 1'b0;
               clk_in   = 1'b1;
               phase_in = PHASE_HIGH;
               wait_in  = bit_d;
            end
            OP_ENTER: begin
               clk_in   = 1'b0;
               data_in  = 1'b0;
               drive_in = 1'b1;
               phase_in = PHASE_SETUP;
               wait_in  = enter_d;
            end
            default: begin
               clk_in   = 1'b1;
               data_in  = 1'b1;
               drive_in = 1'b1;
               phase_in = PHASE_SETUP;
               wait_in  = exit_d;
            end
         endcase
      end else begin
         op_in = OP_IDLE;
      end

      res.clock_level     = clk_in;
      res.data_level      = data_in;
      res.data_drive      = drive_in;
      res.busy_res        = (op_in != OP_IDLE);
      res.read_word       = last_in;
      res.read_valid      = valid;
      res.request_dropped = dropped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff    <= OP_IDLE;
         shift_ff <= '0;
         bits_ff  <= '0;
         phase_ff <= PHASE_SETUP;
         wait_ff  <= '0;
         clk_ff   <= 1'b1;
         data_ff  <= 1'b1;
         drive_ff <= 1'b1;
         last_ff  <= '0;
      end else if (step_en) begin
         op_ff    <= op_in;
         shift_ff <= shift_in;
         bits_ff  <= bits_in;
         phase_ff <= phase_in;
         wait_ff  <= wait_in;
         clk_ff   <= clk_in;
         data_ff  <= data_in;
         drive_ff <= drive_in;
         last_ff  <= last_in;
      end
   end

   idle_is_clean: assert property (@(posedge clock) disable iff (reset)
      op_ff == OP_IDLE |-> phase_ff == PHASE_SETUP && wait_ff == '0)
      else $error("idle with pending phase or wait");

   read_releases_pin: assert property (@(posedge clock) disable iff (reset)
      op_ff == OP_READ |-> !drive_ff)
      else $error("data pin driven during read");

   read_done_drives: assert property (@(posedge clock) disable iff (reset)
      step_en && res.read_valid |-> res.data_drive && !res.busy_res)
      else $error("read finished without restoring drive");

   drop_only_busy: assert property (@(posedge clock) disable iff (reset)
      step_en && res.request_dropped |-> op_ff != OP_IDLE)
      else $error("request dropped while idle");

endmodule
